[hdl/bse_pkg.sv]
package bse_pkg;

	localparam int MAX_ITEMS = 16;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	// sequencer states, one-hot
	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_LOAD    = 7'b0000010,
		ST_STEP    = 7'b0000100,
		ST_FIN     = 7'b0001000,
		ST_OUT_RD  = 7'b0010000,
		ST_OUT_LD  = 7'b0100000,
		ST_OUT_HLD = 7'b1000000
	} state_t;

endpackage

[hdl/bse_ram.sv]
module bse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/bubble_sort_engine.sv]
// channel  | direction | transfer carries
// s_*      | in        | s_tdata[31:0] value, s_tlast last_in
// m_*      | out       | m_tdata[31:0] sorted_value, m_tlast last_out, m_tuser overflowed
// cfg_*    | in        | cfg_data: descending (write only, always ready)
//
// items are stored one per cycle; the marked item starts a sort of n stored values.
// each pass over e+1 values, for e = n-1 down to 1, runs ST_LOAD, a ST_STEP per pair
// (one store read and one write per cycle) and ST_FIN; each result goes out through
// ST_OUT_LD and ST_OUT_HLD; a lone value skips the sort but first reads in ST_OUT_RD.
// one set is handled at a time: s_tready is low from the marked item to the final result.
// arst_n clears sequencer, count, overflow and direction; a stalled result waits in place.
module bubble_sort_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [bse_pkg::DATA_W-1:0]  s_tdata,   // [31:0] value
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [bse_pkg::DATA_W-1:0]  m_tdata,   // [31:0] sorted_value
	output logic                        m_tlast,
	output logic                        m_tuser,   // [0] overflowed
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_data   // [0] descending
);

	bse_pkg::state_t state_q;
	logic [bse_pkg::CNT_W-1:0]  cnt_q;
	logic                       drop_q;
	logic                       desc_q;
	logic [bse_pkg::ADDR_W-1:0] end_q;
	logic [bse_pkg::ADDR_W-1:0] idx_q;
	logic [bse_pkg::DATA_W-1:0] cur_q;
	logic [bse_pkg::DATA_W-1:0] out_data_q;
	logic                       out_last_q;
	logic                       out_ovf_q;

	logic                       s_xfer;
	logic                       has_room;
	logic [bse_pkg::CNT_W-1:0]  n_next;
	logic                       swap;
	logic                       is_final;
	logic                       we;
	logic [bse_pkg::ADDR_W-1:0] waddr;
	logic [bse_pkg::DATA_W-1:0] wdata;
	logic [bse_pkg::ADDR_W-1:0] raddr;
	logic [bse_pkg::DATA_W-1:0] rdata;

	assign s_tready  = (state_q == bse_pkg::ST_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign has_room  = (cnt_q < bse_pkg::CNT_W'(bse_pkg::MAX_ITEMS));
	assign n_next    = has_room ? (cnt_q + bse_pkg::CNT_W'(1)) : cnt_q;
	assign is_final  = (bse_pkg::CNT_W'(idx_q) == (cnt_q - bse_pkg::CNT_W'(1)));

	// carried value moves right past anything that belongs before it
	assign swap = desc_q ? ($signed(cur_q) < $signed(rdata))
	                     : ($signed(cur_q) > $signed(rdata));

	assign m_tvalid = (state_q == bse_pkg::ST_OUT_HLD);
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_ovf_q;

	// store access per state
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = cur_q;
		raddr = '0;
		unique case (state_q)
			bse_pkg::ST_IDLE: begin
				we    = s_xfer && has_room;
				waddr = cnt_q[bse_pkg::ADDR_W-1:0];
				wdata = s_tdata;
			end
			bse_pkg::ST_LOAD: begin
				raddr = bse_pkg::ADDR_W'(1);
			end
			bse_pkg::ST_STEP: begin
				we    = 1'b1;
				waddr = idx_q - bse_pkg::ADDR_W'(1);
				wdata = swap ? rdata : cur_q;
				raddr = idx_q + bse_pkg::ADDR_W'(1);
			end
			bse_pkg::ST_FIN: begin
				we    = 1'b1;
				waddr = end_q;
				wdata = cur_q;
			end
			bse_pkg::ST_OUT_RD: begin
				raddr = '0;
			end
			bse_pkg::ST_OUT_LD: begin
				raddr = '0;
			end
			bse_pkg::ST_OUT_HLD: begin
				raddr = idx_q + bse_pkg::ADDR_W'(1);
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	bse_ram #(
		.WIDTH(bse_pkg::DATA_W),
		.DEPTH(bse_pkg::MAX_ITEMS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// direction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			desc_q <= cfg_data;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			bse_pkg::ST_LOAD: begin
				cur_q <= rdata;
			end
			bse_pkg::ST_STEP: begin
				if (!swap) begin
					cur_q <= rdata;
				end
			end
			bse_pkg::ST_OUT_LD: begin
				out_data_q <= rdata;
				out_last_q <= is_final;
				out_ovf_q  <= is_final && drop_q;
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	// sequencer: collect, sort passes, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bse_pkg::ST_IDLE;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			end_q   <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				bse_pkg::ST_IDLE: begin
					if (s_xfer) begin
						cnt_q <= n_next;
						if (!has_room) begin
							drop_q <= 1'b1;
						end
						if (s_tlast) begin
							end_q <= bse_pkg::ADDR_W'(n_next - bse_pkg::CNT_W'(1));
							if (n_next < bse_pkg::CNT_W'(2)) begin
								state_q <= bse_pkg::ST_OUT_RD;
							end else begin
								state_q <= bse_pkg::ST_LOAD;
							end
						end
					end
				end
				bse_pkg::ST_LOAD: begin
					idx_q   <= bse_pkg::ADDR_W'(1);
					state_q <= bse_pkg::ST_STEP;
				end
				bse_pkg::ST_STEP: begin
					if (idx_q == end_q) begin
						state_q <= bse_pkg::ST_FIN;
					end else begin
						idx_q <= idx_q + bse_pkg::ADDR_W'(1);
					end
				end
				bse_pkg::ST_FIN: begin
					if (end_q == bse_pkg::ADDR_W'(1)) begin
						idx_q   <= '0;
						state_q <= bse_pkg::ST_OUT_LD;
					end else begin
						end_q   <= end_q - bse_pkg::ADDR_W'(1);
						state_q <= bse_pkg::ST_LOAD;
					end
				end
				bse_pkg::ST_OUT_RD: begin
					idx_q   <= '0;
					state_q <= bse_pkg::ST_OUT_LD;
				end
				bse_pkg::ST_OUT_LD: begin
					state_q <= bse_pkg::ST_OUT_HLD;
				end
				bse_pkg::ST_OUT_HLD: begin
					if (m_tready) begin
						if (out_last_q) begin
							cnt_q   <= '0;
							drop_q  <= 1'b0;
							state_q <= bse_pkg::ST_IDLE;
						end else begin
							idx_q   <= idx_q + bse_pkg::ADDR_W'(1);
							state_q <= bse_pkg::ST_OUT_LD;
						end
					end
				end
				default: begin
					state_q <= bse_pkg::ST_IDLE;
				end
			endcase
		end
	end

endmodule
